// File: sv/rtn_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rtn_pkg;

    // queue between the classifier and the letter sequencer
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_BIG = 2'd1;
    localparam logic [1:0] ST_NEG = 2'd2;

    localparam logic [14:0] LIMIT = 15'd4000;

    localparam logic [6:0] ASC_I = 7'h49;
    localparam logic [6:0] ASC_V = 7'h56;
    localparam logic [6:0] ASC_X = 7'h58;
    localparam logic [6:0] ASC_L = 7'h4C;
    localparam logic [6:0] ASC_C = 7'h43;
    localparam logic [6:0] ASC_D = 7'h44;
    localparam logic [6:0] ASC_M = 7'h4D;

    typedef enum logic [1:0] {
        CLS_OK,
        CLS_ZERO,
        CLS_BIG,
        CLS_NEG
    } cls_t;

    typedef enum logic [1:0] {
        SYM_ONE,
        SYM_FIVE,
        SYM_TEN
    } sym_t;

    typedef struct packed {
        cls_t       cls;
        logic [1:0] th;
        logic [3:0] hu;
        logic [3:0] te;
        logic [3:0] un;
    } entry_t;

    // number of letters for one decimal digit
    function automatic logic [2:0] dig_len(input logic [3:0] d);
        logic [2:0] n;
        unique case (d)
            4'd0:    n = 3'd0;
            4'd1:    n = 3'd1;
            4'd2:    n = 3'd2;
            4'd3:    n = 3'd3;
            4'd4:    n = 3'd2;
            4'd5:    n = 3'd1;
            4'd6:    n = 3'd2;
            4'd7:    n = 3'd3;
            4'd8:    n = 3'd4;
            4'd9:    n = 3'd2;
            default: n = 3'd0;
        endcase
        return n;
    endfunction

    // symbol at position pos inside one digit's pattern
    function automatic sym_t dig_sym(input logic [3:0] d, input logic [1:0] pos);
        sym_t s;
        unique case (d)
            4'd4:                s = (pos == 2'd0) ? SYM_ONE : SYM_FIVE;
            4'd5:                s = SYM_FIVE;
            4'd6, 4'd7, 4'd8:    s = (pos == 2'd0) ? SYM_FIVE : SYM_ONE;
            4'd9:                s = (pos == 2'd0) ? SYM_ONE : SYM_TEN;
            default:             s = SYM_ONE;
        endcase
        return s;
    endfunction

    // place 0 thousands, 1 hundreds, 2 tens, 3 units
    function automatic logic [6:0] roman_letter(input logic [1:0] place, input sym_t s);
        logic [6:0] c;
        unique case (place)
            2'd0: c = ASC_M;
            2'd1: c = (s == SYM_ONE) ? ASC_C : ((s == SYM_FIVE) ? ASC_D : ASC_M);
            2'd2: c = (s == SYM_ONE) ? ASC_X : ((s == SYM_FIVE) ? ASC_L : ASC_C);
            2'd3: c = (s == SYM_ONE) ? ASC_I : ((s == SYM_FIVE) ? ASC_V : ASC_X);
            default: c = ASC_M;
        endcase
        return c;
    endfunction

    function automatic logic [1:0] cls_status(input cls_t c);
        logic [1:0] s;
        unique case (c)
            CLS_BIG: s = ST_BIG;
            CLS_NEG: s = ST_NEG;
            default: s = ST_OK;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

// File: sv/rtn_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module rtn_queue
    import rtn_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   wr,
    input  wire entry_t wdata,
    output logic        q_full,
    input  wire logic   rd,
    output entry_t      rdata,
    output logic        q_empty
);

    entry_t             mem_reg [QDEPTH];
    logic [QPTR_W-1:0]  wptr_reg, wptr_next;
    logic [QPTR_W-1:0]  rptr_reg, rptr_next;
    logic [QCNT_W-1:0]  cnt_reg, cnt_next;
    logic               do_wr, do_rd;

    assign q_full  = (cnt_reg == QCNT_W'(QDEPTH));
    assign q_empty = (cnt_reg == '0);
    assign do_wr   = wr && !q_full;
    assign do_rd   = rd && !q_empty;
    assign rdata   = mem_reg[rptr_reg];

    always_comb
    begin
        wptr_next = do_wr ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next = do_rd ? rptr_reg + 1'b1 : rptr_reg;
        cnt_next  = cnt_reg;
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wptr_reg] <= wdata;
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= QCNT_W'(QDEPTH))
        else $error("queue count beyond depth");

    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        (do_wr && !do_rd) |=> (cnt_reg == $past(cnt_reg) + 1'b1))
        else $error("queue count did not follow a write");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != '0 && cnt_reg != QCNT_W'(QDEPTH)) |-> (wptr_reg != rptr_reg))
        else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

// File: sv/rtn_front.sv
`timescale 1ns / 1ps
`default_nettype none

module rtn_front
    import rtn_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire logic [15:0] value,
    output logic             full,
    output logic             q_wr,
    output entry_t           q_data,
    input  wire logic        q_full
);

    // stage 1: class and thousands, stage 2: hundreds, queue write: tens and units
    logic       s1_valid_reg, s1_valid_next;
    cls_t       s1_cls_reg;
    logic [1:0] s1_th_reg;
    logic [9:0] s1_rem_reg;
    logic       s2_valid_reg, s2_valid_next;
    cls_t       s2_cls_reg;
    logic [1:0] s2_th_reg;
    logic [3:0] s2_hu_reg;
    logic [6:0] s2_rem_reg;

    logic        s1_adv, s1_free, s2_free, acc;
    cls_t        in_cls;
    logic [1:0]  in_th;
    logic [11:0] in_sub;
    logic [9:0]  in_rem;
    logic [3:0]  hu;
    logic [9:0]  hu_rem;
    logic [3:0]  te;
    logic [6:0]  te_rem;

    assign q_wr    = s2_valid_reg && !q_full;
    assign s2_free = !s2_valid_reg || q_wr;
    assign s1_adv  = s1_valid_reg && s2_free;
    assign s1_free = !s1_valid_reg || s1_adv;
    assign full    = !s1_free;
    assign acc     = push && s1_free;

    always_comb
    begin
        if (value[15])
        begin
            in_cls = CLS_NEG;
        end
        else if (value[14:0] >= LIMIT)
        begin
            in_cls = CLS_BIG;
        end
        else if (value[14:0] == '0)
        begin
            in_cls = CLS_ZERO;
        end
        else
        begin
            in_cls = CLS_OK;
        end

        if (value[11:0] >= 12'd3000)
        begin
            in_th  = 2'd3;
            in_sub = 12'd3000;
        end
        else if (value[11:0] >= 12'd2000)
        begin
            in_th  = 2'd2;
            in_sub = 12'd2000;
        end
        else if (value[11:0] >= 12'd1000)
        begin
            in_th  = 2'd1;
            in_sub = 12'd1000;
        end
        else
        begin
            in_th  = 2'd0;
            in_sub = 12'd0;
        end
        in_rem = 10'(value[11:0] - in_sub);
    end

    always_comb
    begin
        hu = 4'd0;
        for (int k = 1; k <= 9; k++)
        begin
            if (s1_rem_reg >= 10'(k * 100))
            begin
                hu = 4'(k);
            end
        end
        hu_rem = s1_rem_reg - 10'(hu) * 10'd100;
    end

    always_comb
    begin
        te = 4'd0;
        for (int k = 1; k <= 9; k++)
        begin
            if (s2_rem_reg >= 7'(k * 10))
            begin
                te = 4'(k);
            end
        end
        te_rem     = s2_rem_reg - 7'(te) * 7'd10;
        q_data.cls = s2_cls_reg;
        q_data.th  = s2_th_reg;
        q_data.hu  = s2_hu_reg;
        q_data.te  = te;
        q_data.un  = te_rem[3:0];
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (acc)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end

        s2_valid_next = s2_valid_reg;
        if (s1_adv)
        begin
            s2_valid_next = 1'b1;
        end
        else if (q_wr)
        begin
            s2_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_cls_reg <= in_cls;
            s1_th_reg  <= in_th;
            s1_rem_reg <= in_rem;
        end
        if (s1_adv)
        begin
            s2_cls_reg <= s1_cls_reg;
            s2_th_reg  <= s1_th_reg;
            s2_hu_reg  <= hu;
            s2_rem_reg <= hu_rem[6:0];
        end
    end

    a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && q_full) |=> s2_valid_reg)
        else $error("stage 2 dropped a word while the queue was full");

    a_ok_digits: assert property (@(posedge clk) disable iff (!rst_n)
        (q_wr && q_data.cls == CLS_OK) |-> (q_data.hu <= 4'd9 && q_data.te <= 4'd9
                                            && q_data.un <= 4'd9))
        else $error("decimal digit out of range");

    a_ok_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (q_wr && q_data.cls == CLS_OK) |-> (q_data != '0))
        else $error("nonzero value split into all zero digits");

endmodule

`default_nettype wire

// File: sv/rtn_back.sv
`timescale 1ns / 1ps
`default_nettype none

module rtn_back
    import rtn_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   q_empty,
    input  wire entry_t q_data,
    output logic        q_rd,
    input  wire logic   pop,
    output logic        empty,
    output logic [6:0]  letter,
    output logic        letter_valid,
    output logic [1:0]  status,
    output logic        last
);

    logic       act_reg, act_next;
    entry_t     ent_reg;
    logic [1:0] di_reg, di_next;
    logic [1:0] pos_reg, pos_next;

    logic       ov_reg, ov_next;
    logic [6:0] letter_reg;
    logic       lv_reg;
    logic [1:0] status_reg;
    logic       last_reg;

    logic [3:0] dg [4];
    logic [3:0] ld [4];
    logic       special, out_space, emit, fin, found;
    logic [2:0] len;
    logic [1:0] nxt, first;
    logic [6:0] e_letter;
    logic       e_lv;
    logic [1:0] e_status;

    assign empty        = !ov_reg;
    assign letter       = letter_reg;
    assign letter_valid = lv_reg;
    assign status       = status_reg;
    assign last         = last_reg;

    assign out_space = !ov_reg || pop;
    assign emit      = act_reg && out_space;
    assign special   = (ent_reg.cls != CLS_OK);

    always_comb
    begin
        dg[0] = {2'b00, ent_reg.th};
        dg[1] = ent_reg.hu;
        dg[2] = ent_reg.te;
        dg[3] = ent_reg.un;
        ld[0] = {2'b00, q_data.th};
        ld[1] = q_data.hu;
        ld[2] = q_data.te;
        ld[3] = q_data.un;

        len = dig_len(dg[di_reg]);

        // next nonzero place after the current one
        nxt   = di_reg;
        found = 1'b0;
        for (int j = 3; j >= 0; j--)
        begin
            if (2'(j) > di_reg && dg[j] != 4'd0)
            begin
                nxt   = 2'(j);
                found = 1'b1;
            end
        end

        // first nonzero place of the incoming word
        first = 2'd0;
        for (int j = 3; j >= 0; j--)
        begin
            if (ld[j] != 4'd0)
            begin
                first = 2'(j);
            end
        end
    end

    always_comb
    begin
        di_next  = di_reg;
        pos_next = pos_reg;
        fin      = 1'b0;
        e_letter = roman_letter(di_reg, dig_sym(dg[di_reg], pos_reg));
        e_lv     = 1'b1;
        e_status = ST_OK;

        if (special)
        begin
            e_letter = 7'd0;
            e_lv     = 1'b0;
            e_status = cls_status(ent_reg.cls);
            fin      = 1'b1;
        end
        else if ({1'b0, pos_reg} + 3'd1 < len)
        begin
            pos_next = pos_reg + 1'b1;
        end
        else if (found)
        begin
            di_next  = nxt;
            pos_next = 2'd0;
        end
        else
        begin
            fin = 1'b1;
        end

        q_rd = !q_empty && (!act_reg || (emit && fin));

        act_next = act_reg;
        if (q_rd)
        begin
            act_next = 1'b1;
            di_next  = first;
            pos_next = 2'd0;
        end
        else if (emit && fin)
        begin
            act_next = 1'b0;
        end
        else if (!emit)
        begin
            di_next  = di_reg;
            pos_next = pos_reg;
        end

        ov_next = ov_reg;
        if (emit)
        begin
            ov_next = 1'b1;
        end
        else if (pop)
        begin
            ov_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg <= 1'b0;
            ov_reg  <= 1'b0;
        end
        else
        begin
            act_reg <= act_next;
            ov_reg  <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        di_reg  <= di_next;
        pos_reg <= pos_next;
        if (q_rd)
        begin
            ent_reg <= q_data;
        end
        if (emit)
        begin
            letter_reg <= e_letter;
            lv_reg     <= e_lv;
            status_reg <= e_status;
            last_reg   <= fin;
        end
    end

    a_letter_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && lv_reg) |-> (status_reg == ST_OK && letter_reg != 7'd0))
        else $error("letter word with bad status or empty code");

    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && !lv_reg) |-> last_reg)
        else $error("word without a letter is not the last of its run");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        (act_reg && !special) |-> ({1'b0, pos_reg} < len))
        else $error("letter position past the end of its digit");

endmodule

`default_nettype wire

// File: sv/binary_to_roman_numeral.sv
`timescale 1ns / 1ps
`default_nettype none

// Signed 16-bit value in, Roman numeral out as a run of ASCII letter words.
// Input side: drive value with push high; the word is taken on an edge where full is low.
// Output side: while empty is low the oldest word sits on letter, letter_valid, status
// and last; it is taken on an edge where pop is high.
// Each value from 1 to 3999 gives one word per letter, last set on the final one.
// Zero gives one empty word with status ok; 4000 and up give status too large and
// negative values give status negative, each as a single word with last set.
// A value passes the two classify stages, the queue, then the sequencer load before
// its first word shows.
// Throughput: the letter sequencer puts out one word per cycle while pop keeps the
// output register free; an item gives 1 to 15 words (3888 is the longest), with the next
// item loaded in the cycle its last word goes out.
// A four-word queue splits the classifier from the sequencer; when pop stays low the
// output register holds, the sequencer stops, the queue fills and full rises.
// Reset clears all valid flags and the queue: empty goes high and full goes low.

module binary_to_roman_numeral
    import rtn_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire logic [15:0] value,
    output logic             full,
    output logic             empty,
    input  wire logic        pop,
    output logic [6:0]       letter,
    output logic             letter_valid,
    output logic [1:0]       status,
    output logic             last
);

    logic   q_wr, q_rd, q_full, q_empty;
    entry_t q_wdata, q_rdata;

    rtn_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .value  (value),
        .full   (full),
        .q_wr   (q_wr),
        .q_data (q_wdata),
        .q_full (q_full)
    );

    rtn_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_wr),
        .wdata   (q_wdata),
        .q_full  (q_full),
        .rd      (q_rd),
        .rdata   (q_rdata),
        .q_empty (q_empty)
    );

    rtn_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_data       (q_rdata),
        .q_rd         (q_rd),
        .pop          (pop),
        .empty        (empty),
        .letter       (letter),
        .letter_valid (letter_valid),
        .status       (status),
        .last         (last)
    );

endmodule

`default_nettype wire
